/* rtl/cia_pkg.sv */
// ----------------------------------------------------------------------------
// cia_pkg
// Types and constants shared by the checked integer ALU pipeline.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int unsigned Width = 32;

  localparam logic [Width-1:0] IntMin = {1'b1, {(Width-1){1'b0}}};
  localparam logic [Width-1:0] IntMax = {1'b0, {(Width-1){1'b1}}};

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef struct packed {
    op_e                     kind;
    logic signed [Width-1:0] lhs;
    logic signed [Width-1:0] rhs;
  } req_t;

  typedef struct packed {
    logic signed [Width-1:0] value;
    logic                    invalid;
  } res_t;

  // One slot of the main pipeline: divider state plus the early result.
  typedef struct packed {
    logic             valid;
    op_e              kind;
    logic             neg;
    logic [Width-1:0] mb;
    logic [Width-1:0] rem;
    logic [Width-1:0] quo;
    logic [Width-1:0] val;
    logic             inv;
  } pipe_t;

  // Magnitude limit for a result of the given sign.
  function automatic logic [Width-1:0] limit_of(input logic neg);
    limit_of = neg ? IntMin : IntMax;
  endfunction

endpackage

/* rtl/cia_div_step.sv */
// ----------------------------------------------------------------------------
// cia_div_step
// One restoring division step: one quotient bit, then a pipeline register.
// ----------------------------------------------------------------------------
module cia_div_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cia_pkg::pipe_t stage_i,
  output cia_pkg::pipe_t stage_o
);

  logic [cia_pkg::Width:0]   rem_shift;
  logic [cia_pkg::Width:0]   diff;
  logic                      ge;
  cia_pkg::pipe_t            stage_d;
  cia_pkg::pipe_t            stage_q;

  always_comb begin
    rem_shift = {stage_i.rem, stage_i.quo[cia_pkg::Width-1]};
    diff      = rem_shift - {1'b0, stage_i.mb};
    ge        = ~diff[cia_pkg::Width];
    stage_d     = stage_i;
    stage_d.rem = ge ? diff[cia_pkg::Width-1:0] : rem_shift[cia_pkg::Width-1:0];
    stage_d.quo = {stage_i.quo[cia_pkg::Width-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

/* rtl/cia_mul.sv */
// ----------------------------------------------------------------------------
// cia_mul
// Magnitude multiplier: product register, then range check register.
// ----------------------------------------------------------------------------
module cia_mul (
  input  logic                      clk_i,
  input  logic [cia_pkg::Width-1:0] ma_i,
  input  logic [cia_pkg::Width-1:0] mb_i,
  input  logic                      neg_i,
  output logic [cia_pkg::Width-1:0] val_o,
  output logic                      inv_o
);

  logic [2*cia_pkg::Width-1:0] prod_d;
  logic [2*cia_pkg::Width-1:0] prod_q;
  logic                        neg_q;
  logic [cia_pkg::Width-1:0]   val_d;
  logic [cia_pkg::Width-1:0]   val_q;
  logic                        inv_d;
  logic                        inv_q;

  assign prod_d = ma_i * mb_i;

  always_comb begin
    inv_d = prod_q > {{cia_pkg::Width{1'b0}}, cia_pkg::limit_of(neg_q)};
    val_d = neg_q ? (-prod_q[cia_pkg::Width-1:0]) : prod_q[cia_pkg::Width-1:0];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= neg_i;
    val_q  <= val_d;
    inv_q  <= inv_d;
  end

  assign val_o = val_q;
  assign inv_o = inv_q;

endmodule

/* rtl/checked_integer_alu_unit.sv */
// ----------------------------------------------------------------------------
// checked_integer_alu_unit
// Overflow-checked signed add, subtract, multiply and divide.
// ----------------------------------------------------------------------------
//  channel  | ports                  | transfer when
//  request  | start_i, req_i         | start_i high and busy_o low
//  result   | done_o, res_o          | done_o high, one cycle
//
//  One request per cycle; every result transfers in the order of its request.
//  The divider gives one quotient bit per pipeline stage.
//  Reset clears all valid bits; nothing else is kept between requests.
//  busy_o stays low, the pipeline never stalls.
// ----------------------------------------------------------------------------
module checked_integer_alu_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  cia_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output cia_pkg::res_t res_o
);

  localparam int unsigned W   = cia_pkg::Width;
  localparam int unsigned Lat = W + 3;

  logic           in_vld_q;
  cia_pkg::req_t  in_q;
  cia_pkg::pipe_t prep_d;
  cia_pkg::pipe_t stage_q [0:W];
  cia_pkg::pipe_t step_in [0:W-1];
  logic [W-1:0]   a_sum;
  logic [W-1:0]   a_dif;
  logic [W-1:0]   mul_val;
  logic           mul_inv;
  cia_pkg::pipe_t last;
  logic           div_inv;
  logic [W-1:0]   div_val;
  logic           done_q;
  cia_pkg::res_t  res_d;
  cia_pkg::res_t  res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      in_q     <= '0;
    end else begin
      in_vld_q <= start_i;
      in_q     <= req_i;
    end
  end

  always_comb begin
    a_sum        = in_q.lhs + in_q.rhs;
    a_dif        = in_q.lhs - in_q.rhs;
    prep_d       = '0;
    prep_d.valid = in_vld_q;
    prep_d.kind  = in_q.kind;
    prep_d.neg   = in_q.lhs[W-1] ^ in_q.rhs[W-1];
    prep_d.mb    = in_q.rhs[W-1] ? (-in_q.rhs) : in_q.rhs;
    prep_d.quo   = in_q.lhs[W-1] ? (-in_q.lhs) : in_q.lhs;
    case (in_q.kind)
      cia_pkg::OP_ADD: begin
        prep_d.val = a_sum;
        prep_d.inv = (in_q.lhs[W-1] == in_q.rhs[W-1]) && (a_sum[W-1] != in_q.lhs[W-1]);
      end
      cia_pkg::OP_SUB: begin
        prep_d.val = a_dif;
        prep_d.inv = (in_q.lhs[W-1] != in_q.rhs[W-1]) && (a_dif[W-1] != in_q.lhs[W-1]);
      end
      default: begin
        prep_d.val = '0;
        prep_d.inv = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q[0] <= '0;
    end else begin
      stage_q[0] <= prep_d;
    end
  end

  cia_mul u_mul (
    .clk_i (clk_i),
    .ma_i  (stage_q[0].quo),
    .mb_i  (stage_q[0].mb),
    .neg_i (stage_q[0].neg),
    .val_o (mul_val),
    .inv_o (mul_inv)
  );

  for (genvar i = 0; i < W; i++) begin : g_div
    if (i == 2) begin : g_merge
      always_comb begin
        step_in[i] = stage_q[i];
        if (stage_q[i].kind == cia_pkg::OP_MUL) begin
          step_in[i].val = mul_val;
          step_in[i].inv = mul_inv;
        end
      end
    end else begin : g_pass
      assign step_in[i] = stage_q[i];
    end
    cia_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (step_in[i]),
      .stage_o (stage_q[i+1])
    );
  end

  always_comb begin
    last    = stage_q[W];
    div_inv = (last.mb == '0) || (last.quo > cia_pkg::limit_of(last.neg));
    div_val = last.neg ? (-last.quo) : last.quo;
    if (last.kind == cia_pkg::OP_DIV) begin
      res_d.invalid = div_inv;
      res_d.value   = div_inv ? '0 : div_val;
    end else begin
      res_d.invalid = last.inv;
      res_d.value   = last.inv ? '0 : last.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      res_q  <= '0;
    end else begin
      done_q <= last.valid;
      res_q  <= res_d;
    end
  end

  assign busy_o = 1'b0;
  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Lat))
    else $error("result without a request");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.invalid) |-> (res_o.value == '0))
    else $error("invalid result carries a value");

  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(start_i && req_i.kind == cia_pkg::OP_DIV && req_i.rhs == '0, Lat) && done_o)
      |-> res_o.invalid)
    else $error("divide by zero not flagged");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the checked integer ALU: directed corner rows, most
// with typed-in results, then random operations, the rest checked against a
// local overflow-aware model; random request gaps, none in the last third.
// ----------------------------------------------------------------------------
module tb;

  localparam int Latency   = cia_pkg::Width + 3;
  localparam int NumRandom = 1200;

  typedef struct {
    cia_pkg::op_e               kind;
    logic [cia_pkg::Width-1:0] lhs;
    logic [cia_pkg::Width-1:0] rhs;
    logic                      typed;
    logic [cia_pkg::Width-1:0] value;
    logic                      invalid;
  } row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start_i = 1'b0;
  cia_pkg::req_t  req_i = '0;
  logic           busy_o;
  logic           done_o;
  cia_pkg::res_t  res_o;

  cia_pkg::res_t  expected_q[$];
  int             errors = 0;
  int             gap_pct = 32;

  checked_integer_alu_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("** checked_integer_alu_unit: FAILED **");
    $finish;
  end

  function automatic cia_pkg::res_t alu_result(cia_pkg::op_e kind,
                                               logic [cia_pkg::Width-1:0] a,
                                               logic [cia_pkg::Width-1:0] b);
    longint        sa;
    longint        sb;
    longint        exact;
    cia_pkg::res_t r;
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    r  = '0;
    case (kind)
      cia_pkg::OP_ADD: exact = sa + sb;
      cia_pkg::OP_SUB: exact = sa - sb;
      cia_pkg::OP_MUL: exact = sa * sb;
      default: begin
        if (sb == 0) begin
          r.invalid = 1'b1;
          return r;
        end
        exact = sa / sb;
      end
    endcase
    if (exact > longint'($signed(cia_pkg::IntMax)) ||
        exact < longint'($signed(cia_pkg::IntMin)))
      r.invalid = 1'b1;
    else
      r.value = exact[cia_pkg::Width-1:0];
    return r;
  endfunction

  task automatic issue(cia_pkg::op_e kind, logic [cia_pkg::Width-1:0] a,
                       logic [cia_pkg::Width-1:0] b, cia_pkg::res_t exp);
    start_i <= 1'b1;
    req_i   <= '{kind: kind, lhs: a, rhs: b};
    do @(posedge clk_i); while (busy_o);
    expected_q.push_back(exp);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      req_i   <= '{kind: cia_pkg::op_e'($urandom_range(3)), lhs: $urandom, rhs: $urandom};
      @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: value %0d invalid %0b",
               res_o.value, res_o.invalid);
        errors++;
      end else begin
        cia_pkg::res_t exp;
        exp = expected_q.pop_front();
        if (res_o.value !== exp.value) begin
          $error("value: expected %0d, got %0d", exp.value, res_o.value);
          errors++;
        end
        if (res_o.invalid !== exp.invalid) begin
          $error("invalid: expected %0b, got %0b", exp.invalid, res_o.invalid);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t                      rows[$];
    cia_pkg::res_t             exp;
    logic [cia_pkg::Width-1:0] a;
    logic [cia_pkg::Width-1:0] b;
    cia_pkg::op_e              kind;
    int                        phase;
    logic [cia_pkg::Width-1:0] one;
    logic [cia_pkg::Width-1:0] m1;
    logic [cia_pkg::Width-1:0] imax;
    logic [cia_pkg::Width-1:0] imin;
    one  = 1;
    m1   = '1;
    imax = cia_pkg::IntMax;
    imin = cia_pkg::IntMin;
    rows = '{
      '{cia_pkg::OP_ADD, imax, one, 1'b1, '0, 1'b1},
      '{cia_pkg::OP_ADD, imin, m1, 1'b1, '0, 1'b1},
      '{cia_pkg::OP_ADD, imax, imin, 1'b1, m1, 1'b0},
      '{cia_pkg::OP_ADD, '0, '0, 1'b1, '0, 1'b0},
      '{cia_pkg::OP_SUB, imin, one, 1'b1, '0, 1'b1},
      '{cia_pkg::OP_SUB, '0, imin, 1'b1, '0, 1'b1},
      '{cia_pkg::OP_SUB, m1, imin, 1'b1, imax, 1'b0},
      '{cia_pkg::OP_SUB, imax, m1, 1'b1, '0, 1'b1},
      '{cia_pkg::OP_MUL, imin, one, 1'b1, imin, 1'b0},
      '{cia_pkg::OP_MUL, imin, m1, 1'b1, '0, 1'b1},
      '{cia_pkg::OP_MUL, imax, m1, 1'b0, '0, 1'b0},
      '{cia_pkg::OP_MUL, 32'h0001_0000, 32'h0000_8000, 1'b1, '0, 1'b1},
      '{cia_pkg::OP_MUL, 32'hFFFF_0000, 32'h0000_8000, 1'b1, imin, 1'b0},
      '{cia_pkg::OP_MUL, 32'h0000_B505, 32'h0000_B505, 1'b0, '0, 1'b0},
      '{cia_pkg::OP_MUL, '0, imin, 1'b1, '0, 1'b0},
      '{cia_pkg::OP_DIV, imin, m1, 1'b1, '0, 1'b1},
      '{cia_pkg::OP_DIV, imax, '0, 1'b1, '0, 1'b1},
      '{cia_pkg::OP_DIV, '0, '0, 1'b1, '0, 1'b1},
      '{cia_pkg::OP_DIV, imin, one, 1'b1, imin, 1'b0},
      '{cia_pkg::OP_DIV, 32'hFFFF_FFF9, 32'd2, 1'b1, 32'hFFFF_FFFD, 1'b0},
      '{cia_pkg::OP_DIV, 32'd7, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFD, 1'b0},
      '{cia_pkg::OP_DIV, imax, imin, 1'b1, '0, 1'b0},
      '{cia_pkg::OP_DIV, imin, imin, 1'b1, one, 1'b0}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        exp.value   = rows[i].value;
        exp.invalid = rows[i].invalid;
      end else begin
        exp = alu_result(rows[i].kind, rows[i].lhs, rows[i].rhs);
      end
      issue(rows[i].kind, rows[i].lhs, rows[i].rhs, exp);
    end
    for (int n = 0; n < NumRandom; n++) begin
      phase   = n * 3 / NumRandom;
      gap_pct = (phase == 0) ? 32 : (phase == 1) ? 51 : 0;
      kind = cia_pkg::op_e'($urandom_range(3));
      a = $urandom;
      b = $urandom;
      case ($urandom_range(7))
        0: a = $signed(a) >>> $urandom_range(31);
        1: b = $signed(b) >>> $urandom_range(31);
        2: begin
          a = $signed(a) >>> $urandom_range(16, 31);
          b = $signed(b) >>> $urandom_range(16, 31);
        end
        3: b = $urandom_range(3) - 1;
        4: a = ($urandom_range(1)) ? imin : imax;
        default: ;
      endcase
      issue(kind, a, b, alu_result(kind, a, b));
    end
    start_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** checked_integer_alu_unit: PASSED **");
    end else begin
      $display("** checked_integer_alu_unit: FAILED **");
    end
    $finish;
  end

endmodule
